// ===== rtl/backtrack_bucket_assign_stack_unit_macros.svh =====
// Assertion helpers for the bucket assignment stack RTL.
// Each macro expects clk and rst_n in scope.
`ifndef BACKTRACK_BUCKET_ASSIGN_STACK_UNIT_MACROS_SVH
`define BACKTRACK_BUCKET_ASSIGN_STACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BBAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define BBAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bbas_pkg.sv =====
package bbas_pkg;

  // Fixed dimensions of the search state
  localparam int MAX_GROUPS  = 4;
  localparam int MAX_BUCKETS = 64;
  localparam int MAX_KEYS    = 64;

  localparam int GRP_W   = 2;
  localparam int FLAT_W  = 6;
  localparam int KEY_W   = 6;
  localparam int FILL_W  = 7;
  localparam int USED_W  = 4;
  localparam int DEPTH_W = 7;
  localparam int SLOT_AW = FLAT_W + KEY_W;
  localparam int CFG_W   = 28;

  localparam logic [FILL_W-1:0]  KEY_LIMIT    = FILL_W'(MAX_KEYS);
  localparam logic [DEPTH_W-1:0] BUCKET_LIMIT = DEPTH_W'(MAX_BUCKETS);

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNTS = 2'd0;
  localparam logic [1:0] CFG_CAPS   = 2'd1;
  localparam logic [1:0] CFG_KEYS   = 2'd2;

  // Search phase codes
  localparam logic [1:0] PH_BUCKET = 2'd0;
  localparam logic [1:0] PH_KEY    = 2'd1;
  localparam logic [1:0] PH_END    = 2'd2;

  typedef enum logic [2:0] {
    ACT_ADD_KEY     = 3'd0,
    ACT_UNDO_KEY    = 3'd1,
    ACT_ADD_BUCKET  = 3'd2,
    ACT_UNDO_BUCKET = 3'd3,
    ACT_QUERY       = 3'd4,
    ACT_READ_SLOT   = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [KEY_W-1:0]  key_id;
    logic [GRP_W-1:0]  grp_sel;
    logic [FLAT_W-1:0] bucket_index;
    logic [KEY_W-1:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          phase;
    logic                group_full;
    logic [FLAT_W-1:0]   latest_bucket;
    logic [FILL_W-1:0]   current_fill;
    logic [MAX_KEYS-1:0] unused_keys;
    logic [KEY_W-1:0]    read_key;
    logic                error;
  } out_word_t;

  // Memory port requests from the sequencer
  typedef struct packed {
    logic              we;
    logic [FLAT_W-1:0] waddr;
    logic [FILL_W-1:0] wdata;
    logic              re;
    logic [FLAT_W-1:0] raddr;
  } fill_req_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] waddr;
    logic [KEY_W-1:0]   wdata;
    logic               re;
    logic [SLOT_AW-1:0] raddr;
  } slot_req_t;

  typedef struct packed {
    logic              we;
    logic [FLAT_W-1:0] waddr;
    logic [GRP_W-1:0]  wdata;
    logic              re;
    logic [FLAT_W-1:0] raddr;
  } stk_req_t;

  // Bucket count of one group
  function automatic logic [USED_W-1:0] grp_count(input logic [15:0] counts,
                                                  input logic [GRP_W-1:0] g);
    return counts[{g, 2'b00} +: USED_W];
  endfunction

  // Capacity of one group, saturated at the key limit
  function automatic logic [FILL_W-1:0] grp_cap(input logic [CFG_W-1:0] caps,
                                                input logic [GRP_W-1:0] g);
    logic [4:0]        lsb;
    logic [FILL_W-1:0] c;
    lsb = 5'(g) * 5'd7;
    c   = caps[lsb +: FILL_W];
    return (c > KEY_LIMIT) ? KEY_LIMIT : c;
  endfunction

  // First flat index of a group: sum of the counts below it
  function automatic logic [FLAT_W-1:0] grp_base(input logic [15:0] counts,
                                                 input logic [GRP_W-1:0] g);
    logic [FLAT_W-1:0] s;
    s = '0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if (GRP_W'(i) < g) begin
        s = s + FLAT_W'(counts[i*4 +: USED_W]);
      end
    end
    return s;
  endfunction

  // Total bucket count over all groups, capped at the bucket limit
  function automatic logic [DEPTH_W-1:0] total_buckets(input logic [15:0] counts);
    logic [DEPTH_W-1:0] t;
    t = '0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      t = t + DEPTH_W'(counts[i*4 +: USED_W]);
    end
    return (t > BUCKET_LIMIT) ? BUCKET_LIMIT : t;
  endfunction

  // One bit per key below the key count
  function automatic logic [MAX_KEYS-1:0] key_mask(input logic [FILL_W-1:0] kc);
    logic [FILL_W-1:0] k;
    k = (kc > KEY_LIMIT) ? KEY_LIMIT : kc;
    if (k >= KEY_LIMIT) begin
      return '1;
    end
    return (MAX_KEYS'(1) << k) - MAX_KEYS'(1);
  endfunction

  // Flat index of the newest bucket of a group with 'used' open buckets
  function automatic logic [FLAT_W-1:0] flat_of(input logic [15:0] counts,
                                                input logic [GRP_W-1:0] g,
                                                input logic [USED_W-1:0] used);
    return grp_base(counts, g) + FLAT_W'(used) - FLAT_W'(1);
  endfunction

endpackage

// ===== rtl/bbas_ram.sv =====
module bbas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/bbas_core.sv =====
module bbas_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [bbas_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bbas_pkg::in_word_t              in_word,
  input  logic                            res_take,
  output logic                            res_valid,
  output bbas_pkg::out_word_t             res_word,
  output bbas_pkg::fill_req_t             fill_req,
  input  logic [bbas_pkg::FILL_W-1:0]     fill_q,
  output bbas_pkg::slot_req_t             slot_req,
  input  logic [bbas_pkg::KEY_W-1:0]      slot_q,
  output bbas_pkg::stk_req_t              stk_req,
  input  logic [bbas_pkg::GRP_W-1:0]      stk_q
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXE  = 5'b00010,
    S_UNK  = 5'b00100,
    S_FIL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [15:0]                  counts_r;
  logic [bbas_pkg::CFG_W-1:0]   caps_r;
  logic [bbas_pkg::FILL_W-1:0]  kcnt_r;

  // Search state held in flops
  logic [bbas_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [bbas_pkg::GRP_W-1:0]    top_r, top_nxt;
  logic [bbas_pkg::USED_W-1:0]   used_r [bbas_pkg::MAX_GROUPS];
  logic [bbas_pkg::USED_W-1:0]   used_nxt [bbas_pkg::MAX_GROUPS];
  logic [bbas_pkg::MAX_KEYS-1:0] mask_r, mask_nxt;
  logic [bbas_pkg::MAX_BUCKETS-1:0] fvalid_r, fvalid_nxt;

  // Per-word working registers
  bbas_pkg::in_word_t            req_r, req_nxt;
  logic [bbas_pkg::FLAT_W-1:0]   fraddr_r, fraddr_nxt;
  logic [bbas_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [bbas_pkg::KEY_W-1:0]    rkey_r, rkey_nxt;
  logic                          err_r, err_nxt;

  logic [bbas_pkg::FLAT_W-1:0]   cur_flat;
  logic [bbas_pkg::FLAT_W-1:0]   post_flat;
  logic [bbas_pkg::FILL_W-1:0]   fill_rd;
  logic [bbas_pkg::FILL_W-1:0]   cap_top;
  logic [bbas_pkg::MAX_KEYS-1:0] kmask;
  logic [bbas_pkg::USED_W-1:0]   used_g;
  logic                          reread;

  // Newest bucket from the current state
  assign cur_flat = bbas_pkg::flat_of(counts_r, top_r, used_r[top_r]);
  assign cap_top  = bbas_pkg::grp_cap(caps_r, top_r);
  assign kmask    = bbas_pkg::key_mask(kcnt_r);
  assign used_g   = used_r[req_r.grp_sel];

  // Fill entries never written read as zero
  assign fill_rd = fvalid_r[fraddr_r] ? fill_q : '0;

  // Sequencer: issue reads on accept, execute, finish any follow-up read, then offer the result
  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    top_nxt    = top_r;
    used_nxt   = used_r;
    mask_nxt   = mask_r;
    fvalid_nxt = fvalid_r;
    req_nxt    = req_r;
    fraddr_nxt = fraddr_r;
    fill_nxt   = fill_r;
    rkey_nxt   = rkey_r;
    err_nxt    = err_r;
    fill_req   = '0;
    slot_req   = '0;
    stk_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    reread     = 1'b0;
    post_flat  = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EXE: begin
        err_nxt   = 1'b0;
        rkey_nxt  = '0;
        fill_nxt  = fill_rd;
        state_nxt = S_FIN;
        case (req_r.action)
          bbas_pkg::ACT_ADD_KEY: begin
            if (depth_r == '0 || fill_rd >= cap_top || !kmask[req_r.key_id] ||
                mask_r[req_r.key_id]) begin
              err_nxt = 1'b1;
            end else begin
              slot_req.we    = 1'b1;
              slot_req.waddr = {cur_flat, fill_rd[bbas_pkg::KEY_W-1:0]};
              slot_req.wdata = req_r.key_id;
              fill_req.we    = 1'b1;
              fill_req.waddr = cur_flat;
              fill_req.wdata = fill_rd + 7'd1;
              fvalid_nxt[cur_flat]   = 1'b1;
              mask_nxt[req_r.key_id] = 1'b1;
              fill_nxt = fill_rd + 7'd1;
            end
          end
          bbas_pkg::ACT_UNDO_KEY: begin
            if (depth_r == '0 || fill_rd == '0) begin
              err_nxt = 1'b1;
            end else begin
              slot_req.re    = 1'b1;
              slot_req.raddr = {cur_flat, bbas_pkg::KEY_W'(fill_rd - 7'd1)};
              fill_req.we    = 1'b1;
              fill_req.waddr = cur_flat;
              fill_req.wdata = fill_rd - 7'd1;
              fill_nxt  = fill_rd - 7'd1;
              state_nxt = S_UNK;
            end
          end
          bbas_pkg::ACT_ADD_BUCKET: begin
            if (depth_r >= bbas_pkg::BUCKET_LIMIT ||
                used_g >= bbas_pkg::grp_count(counts_r, req_r.grp_sel) ||
                (7'(bbas_pkg::grp_base(counts_r, req_r.grp_sel)) + 7'(used_g)) >=
                bbas_pkg::BUCKET_LIMIT) begin
              err_nxt = 1'b1;
            end else begin
              used_nxt[req_r.grp_sel] = used_g + 4'd1;
              stk_req.we    = 1'b1;
              stk_req.waddr = depth_r[bbas_pkg::FLAT_W-1:0];
              stk_req.wdata = req_r.grp_sel;
              depth_nxt = depth_r + 7'd1;
              top_nxt   = req_r.grp_sel;
              reread    = 1'b1;
            end
          end
          bbas_pkg::ACT_UNDO_BUCKET: begin
            if (depth_r == '0 || fill_rd != '0) begin
              err_nxt = 1'b1;
            end else begin
              if (used_r[top_r] != '0) begin
                used_nxt[top_r] = used_r[top_r] - 4'd1;
              end
              depth_nxt = depth_r - 7'd1;
              top_nxt   = stk_q;
              reread    = 1'b1;
            end
          end
          bbas_pkg::ACT_QUERY: begin
          end
          bbas_pkg::ACT_READ_SLOT: begin
            if (7'(req_r.slot_index) < fill_rd) begin
              rkey_nxt = slot_q;
            end
            reread = 1'b1;
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
        // Fetch the fill of the newest bucket after the action
        post_flat = bbas_pkg::flat_of(counts_r, top_nxt, used_nxt[top_nxt]);
        if (reread) begin
          fill_req.re    = 1'b1;
          fill_req.raddr = post_flat;
          fraddr_nxt     = post_flat;
          state_nxt      = S_FIL;
        end
      end
      S_UNK: begin
        // Drop the key that left the bucket
        mask_nxt[slot_q] = 1'b0;
        state_nxt = S_FIN;
      end
      S_FIL: begin
        fill_nxt  = fill_rd;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_valid = 1'b1;
        in_ready  = res_take;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Accept: latch the word and start the reads it may need
    if (in_valid && in_ready) begin
      req_nxt        = in_word;
      fill_req.re    = 1'b1;
      fill_req.raddr = (in_word.action == bbas_pkg::ACT_READ_SLOT) ?
                       in_word.bucket_index : cur_flat;
      fraddr_nxt     = fill_req.raddr;
      slot_req.re    = 1'b1;
      slot_req.raddr = {in_word.bucket_index, in_word.slot_index};
      stk_req.re     = 1'b1;
      stk_req.raddr  = bbas_pkg::FLAT_W'(depth_r - 7'd2);
      state_nxt      = S_EXE;
    end
  end

  // Result word from committed state
  always_comb begin
    res_word = '0;
    if (depth_r == '0) begin
      res_word.phase = bbas_pkg::PH_BUCKET;
    end else if (fill_r < cap_top) begin
      res_word.phase = bbas_pkg::PH_KEY;
    end else if (depth_r < bbas_pkg::total_buckets(counts_r)) begin
      res_word.phase = bbas_pkg::PH_BUCKET;
    end else begin
      res_word.phase = bbas_pkg::PH_END;
    end
    res_word.group_full    = (used_g >= bbas_pkg::grp_count(counts_r, req_r.grp_sel));
    res_word.latest_bucket = (depth_r == '0) ? '0 : cur_flat;
    res_word.current_fill  = (depth_r == '0) ? '0 : fill_r;
    res_word.unused_keys   = ~mask_r & kmask;
    res_word.read_key      = rkey_r;
    res_word.error         = err_r;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      depth_r  <= '0;
      top_r    <= '0;
      used_r   <= '{default: '0};
      mask_r   <= '0;
      fvalid_r <= '0;
      counts_r <= '0;
      caps_r   <= '0;
      kcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      depth_r  <= depth_nxt;
      top_r    <= top_nxt;
      used_r   <= used_nxt;
      mask_r   <= mask_nxt;
      fvalid_r <= fvalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bbas_pkg::CFG_COUNTS: counts_r <= cfg_data[15:0];
          bbas_pkg::CFG_CAPS:   caps_r   <= cfg_data;
          bbas_pkg::CFG_KEYS:   kcnt_r   <= cfg_data[bbas_pkg::FILL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    fraddr_r <= fraddr_nxt;
    fill_r   <= fill_nxt;
    rkey_r   <= rkey_nxt;
    err_r    <= err_nxt;
  end

endmodule

// ===== rtl/backtrack_bucket_assign_stack_unit.sv =====
// Channel | Handshake            | Word
// --------+----------------------+----------------------------------------
// in      | in_valid / in_ready  | in_word  (action, key, group, bucket, slot)
// out     | out_valid / out_ready| out_word (phase, fill, masks, read key)
// cfg     | cfg_we               | cfg_index, cfg_data (no read-back)
//
// An item is accepted, then executed using the fill-store read issued at
// accept; legal add bucket, legal undo bucket and read slot add a second
// fill-store read for the newest bucket, legal undo key adds a slot read
// of the removed key. The next item is accepted in the result cycle.
// Synchronous active-low reset; fill store validity lives in per-bucket
// flops, so no clearing pass is run. A full output register stalls the
// sequencer in its result cycle.
`include "backtrack_bucket_assign_stack_unit_macros.svh"

module backtrack_bucket_assign_stack_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bbas_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bbas_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbas_pkg::out_word_t        out_word
);

  bbas_pkg::fill_req_t fill_req;
  bbas_pkg::slot_req_t slot_req;
  bbas_pkg::stk_req_t  stk_req;

  logic [bbas_pkg::FILL_W-1:0] fill_q;
  logic [bbas_pkg::KEY_W-1:0]  slot_q;
  logic [bbas_pkg::GRP_W-1:0]  stk_q;

  logic                res_take;
  logic                res_valid;
  bbas_pkg::out_word_t res_word;

  logic                out_valid_r;
  bbas_pkg::out_word_t out_word_r;

  bbas_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res_word  (res_word),
    .fill_req  (fill_req),
    .fill_q    (fill_q),
    .slot_req  (slot_req),
    .slot_q    (slot_q),
    .stk_req   (stk_req),
    .stk_q     (stk_q)
  );

  // Fill count of every bucket
  bbas_ram #(
    .WIDTH (bbas_pkg::FILL_W),
    .DEPTH (bbas_pkg::MAX_BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_req.we),
    .waddr (fill_req.waddr),
    .wdata (fill_req.wdata),
    .re    (fill_req.re),
    .raddr (fill_req.raddr),
    .rdata (fill_q)
  );

  // Key slots, one row per bucket
  bbas_ram #(
    .WIDTH (bbas_pkg::KEY_W),
    .DEPTH (bbas_pkg::MAX_BUCKETS * bbas_pkg::MAX_KEYS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_req.we),
    .waddr (slot_req.waddr),
    .wdata (slot_req.wdata),
    .re    (slot_req.re),
    .raddr (slot_req.raddr),
    .rdata (slot_q)
  );

  // Group of each opened bucket, in opening order
  bbas_ram #(
    .WIDTH (bbas_pkg::GRP_W),
    .DEPTH (bbas_pkg::MAX_BUCKETS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .re    (stk_req.re),
    .raddr (stk_req.raddr),
    .rdata (stk_q)
  );

  // Output register: take a result when empty or being drained
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BBAS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `BBAS_ASSERT_NEXT(a_result_held, res_valid && !res_take, res_valid && $stable(res_word), "result lost")
  `BBAS_ASSERT_NOW(a_phase_code, out_valid_r, out_word_r.phase <= bbas_pkg::PH_END, "bad phase")

endmodule
